// ===== rtl/dbfc_pkg.sv =====
// Shared constants for the depth band false-color mapper.
// Used by dbfc_front, dbfc_div_cell and depth_band_false_color_map.
`timescale 1ns / 1ps

package dbfc_pkg;

    // Default sample width and result width
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int QUOT_BITS       = 8;
    localparam int FULL_SCALE      = 255;

    // Color lanes
    localparam int NUM_LANES = 3;
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_LOW    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RED_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_LOW  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_HIGH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_LOW   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_HIGH  = 3'd5;

    // Band bounds after reset
    localparam int RED_LOW_RST    = 84;
    localparam int RED_HIGH_RST   = 90;
    localparam int GREEN_LOW_RST  = 82;
    localparam int GREEN_HIGH_RST = 88;
    localparam int BLUE_LOW_RST   = 80;
    localparam int BLUE_HIGH_RST  = 82;

endpackage

// ===== rtl/dbfc_front.sv =====
// Front stage: band test, numerator*255 and span per color lane.
// Depends on dbfc_pkg. Feeds the chain of dbfc_div_cell.
`timescale 1ns / 1ps

module dbfc_front #(
    parameter int SAMPLE_BITS = dbfc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            up_valid,
    output logic                                            up_ready,
    input  logic [SAMPLE_BITS-1:0]                          depth_value,
    input  logic [SAMPLE_BITS-1:0]                          red_low,
    input  logic [SAMPLE_BITS-1:0]                          red_high,
    input  logic [SAMPLE_BITS-1:0]                          green_low,
    input  logic [SAMPLE_BITS-1:0]                          green_high,
    input  logic [SAMPLE_BITS-1:0]                          blue_low,
    input  logic [SAMPLE_BITS-1:0]                          blue_high,
    output logic                                            down_valid,
    input  logic                                            down_ready,
    output logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS+dbfc_pkg::QUOT_BITS-1:0] rem_out,
    output logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] den_out
);
    import dbfc_pkg::*;

    localparam int REM_BITS = SAMPLE_BITS + QUOT_BITS;

    logic                                      valid_reg;
    logic [NUM_LANES-1:0][REM_BITS-1:0]        rem_reg;
    logic [NUM_LANES-1:0][REM_BITS-1:0]        rem_next;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]     den_reg;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]     den_next;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]     num;
    logic [NUM_LANES-1:0]                      in_band;
    logic [SAMPLE_BITS:0]                      green_sum;
    logic [SAMPLE_BITS-1:0]                    green_mid;
    logic [SAMPLE_BITS-1:0]                    den_one;
    logic [REM_BITS-1:0]                       full_val;

    assign den_one  = SAMPLE_BITS'(1);
    assign full_val = REM_BITS'(FULL_SCALE);
    assign up_ready = !valid_reg || down_ready;

    // Band membership and ramp terms
    always_comb
    begin
        green_sum = {1'b0, green_low} + {1'b0, green_high};
        green_mid = green_sum[SAMPLE_BITS:1];

        in_band[LANE_RED]   = (depth_value >= red_low)   && (depth_value <= red_high);
        in_band[LANE_GREEN] = (depth_value >= green_low) && (depth_value <= green_high);
        in_band[LANE_BLUE]  = (depth_value >= blue_low)  && (depth_value <= blue_high);

        num[LANE_RED]      = depth_value - red_low;
        den_next[LANE_RED] = red_high - red_low;
        num[LANE_BLUE]      = blue_high - depth_value;
        den_next[LANE_BLUE] = blue_high - blue_low;
        // Falling half wins at the midpoint
        if (depth_value >= green_mid)
        begin
            num[LANE_GREEN]      = green_high - depth_value;
            den_next[LANE_GREEN] = green_high - green_mid;
        end
        else
        begin
            num[LANE_GREEN]      = depth_value - green_low;
            den_next[LANE_GREEN] = green_mid - green_low;
        end

        // num*255 as (num << 8) - num
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rem_next[i] = {num[i], {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, num[i]};
        end

        // Outside band gives 0; zero span gives 0 for red, full scale otherwise.
        // Forced values go through the divider as x/1.
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (!in_band[i])
            begin
                rem_next[i] = '0;
                den_next[i] = den_one;
            end
            else if (den_next[i] == '0)
            begin
                rem_next[i] = (i == LANE_RED) ? '0 : full_val;
                den_next[i] = den_one;
            end
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg <= rem_next;
            den_reg <= den_next;
        end
    end

    assign down_valid = valid_reg;
    assign rem_out    = rem_reg;
    assign den_out    = den_reg;

endmodule

// ===== rtl/dbfc_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit for all color lanes.
// Depends on dbfc_pkg. Instantiated QUOT_BITS times by the top level.
`timescale 1ns / 1ps

module dbfc_div_cell #(
    parameter int SAMPLE_BITS = dbfc_pkg::SAMPLE_BITS_DEF,
    parameter int BIT_POS     = 0
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            up_valid,
    output logic                                            up_ready,
    input  logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS+dbfc_pkg::QUOT_BITS-1:0] rem_in,
    input  logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] den_in,
    input  logic [dbfc_pkg::NUM_LANES-1:0][dbfc_pkg::QUOT_BITS-1:0] quot_in,
    output logic                                            down_valid,
    input  logic                                            down_ready,
    output logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS+dbfc_pkg::QUOT_BITS-1:0] rem_out,
    output logic [dbfc_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] den_out,
    output logic [dbfc_pkg::NUM_LANES-1:0][dbfc_pkg::QUOT_BITS-1:0] quot_out
);
    import dbfc_pkg::*;

    localparam int REM_BITS = SAMPLE_BITS + QUOT_BITS;

    logic                                   valid_reg;
    logic [NUM_LANES-1:0][REM_BITS-1:0]     rem_reg;
    logic [NUM_LANES-1:0][REM_BITS-1:0]     rem_next;
    logic [NUM_LANES-1:0][SAMPLE_BITS-1:0]  den_reg;
    logic [NUM_LANES-1:0][QUOT_BITS-1:0]    quot_reg;
    logic [NUM_LANES-1:0][QUOT_BITS-1:0]    quot_next;
    logic [NUM_LANES-1:0][REM_BITS-1:0]     den_shift;

    assign up_ready = !valid_reg || down_ready;

    // Restoring step: compare against the span shifted to this bit
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            den_shift[i] = REM_BITS'({{QUOT_BITS{1'b0}}, den_in[i]} << BIT_POS);
            quot_next[i] = quot_in[i];
            if (rem_in[i] >= den_shift[i])
            begin
                rem_next[i]           = rem_in[i] - den_shift[i];
                quot_next[i][BIT_POS] = 1'b1;
            end
            else
            begin
                rem_next[i]           = rem_in[i];
                quot_next[i][BIT_POS] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quot_reg <= quot_next;
        end
    end

    assign down_valid = valid_reg;
    assign rem_out    = rem_reg;
    assign den_out    = den_reg;
    assign quot_out   = quot_reg;

endmodule

// ===== rtl/depth_band_false_color_map.sv =====
// Depth band false-color mapper, top level.
// Depends on dbfc_pkg, dbfc_front and dbfc_div_cell.
//
// Usage:
//   Input channel (in_valid/in_ready, depth_value) takes one depth sample per
//   transaction; output channel (out_valid/out_ready, red_out, green_out,
//   blue_out) returns one RGB pixel per sample, in order.
//   Band bounds are written through cfg_wr_en/cfg_index/cfg_data while the
//   block is empty, a rule the block does not enforce; the user must keep
//   it. Indexes above 5 are ignored. The pipeline is one front stage (band
//   test, num*255, span) and a chain of 8 divider cells, each settling one
//   quotient bit per lane. Throughput is one sample per cycle while
//   out_ready is high; each stage holds its transaction and hands it on.
//   When out_ready is low the chain fills up stage by stage; each stage holds
//   while the next is occupied, and in_ready drops only when all 9 stages
//   are full, so no transaction is lost or repeated.
//   Reset clears all stage valid bits and loads the default band bounds.
`timescale 1ns / 1ps

module depth_band_false_color_map #(
    parameter int SAMPLE_BITS = dbfc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              depth_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dbfc_pkg::QUOT_BITS-1:0]      red_out,
    output logic [dbfc_pkg::QUOT_BITS-1:0]      green_out,
    output logic [dbfc_pkg::QUOT_BITS-1:0]      blue_out,
    input  logic                                cfg_wr_en,
    input  logic [dbfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data
);
    import dbfc_pkg::*;

    localparam int REM_BITS = SAMPLE_BITS + QUOT_BITS;

    // Band bound registers
    logic [SAMPLE_BITS-1:0] red_low_reg;
    logic [SAMPLE_BITS-1:0] red_high_reg;
    logic [SAMPLE_BITS-1:0] green_low_reg;
    logic [SAMPLE_BITS-1:0] green_high_reg;
    logic [SAMPLE_BITS-1:0] blue_low_reg;
    logic [SAMPLE_BITS-1:0] blue_high_reg;

    // Chain links: link 0 is the front stage output
    logic [QUOT_BITS:0]                                      link_valid;
    logic [QUOT_BITS:0]                                      link_ready;
    logic [QUOT_BITS:0][NUM_LANES-1:0][REM_BITS-1:0]         link_rem;
    logic [QUOT_BITS:0][NUM_LANES-1:0][SAMPLE_BITS-1:0]      link_den;
    logic [QUOT_BITS:0][NUM_LANES-1:0][QUOT_BITS-1:0]        link_quot;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_low_reg    <= SAMPLE_BITS'(RED_LOW_RST);
            red_high_reg   <= SAMPLE_BITS'(RED_HIGH_RST);
            green_low_reg  <= SAMPLE_BITS'(GREEN_LOW_RST);
            green_high_reg <= SAMPLE_BITS'(GREEN_HIGH_RST);
            blue_low_reg   <= SAMPLE_BITS'(BLUE_LOW_RST);
            blue_high_reg  <= SAMPLE_BITS'(BLUE_HIGH_RST);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RED_LOW:    red_low_reg    <= cfg_data;
                REG_RED_HIGH:   red_high_reg   <= cfg_data;
                REG_GREEN_LOW:  green_low_reg  <= cfg_data;
                REG_GREEN_HIGH: green_high_reg <= cfg_data;
                REG_BLUE_LOW:   blue_low_reg   <= cfg_data;
                REG_BLUE_HIGH:  blue_high_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Front stage
    dbfc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .up_ready    (in_ready),
        .depth_value (depth_value),
        .red_low     (red_low_reg),
        .red_high    (red_high_reg),
        .green_low   (green_low_reg),
        .green_high  (green_high_reg),
        .blue_low    (blue_low_reg),
        .blue_high   (blue_high_reg),
        .down_valid  (link_valid[0]),
        .down_ready  (link_ready[0]),
        .rem_out     (link_rem[0]),
        .den_out     (link_den[0])
    );

    assign link_quot[0] = '0;

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_cell
        dbfc_div_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .BIT_POS     (QUOT_BITS - 1 - g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[g]),
            .up_ready   (link_ready[g]),
            .rem_in     (link_rem[g]),
            .den_in     (link_den[g]),
            .quot_in    (link_quot[g]),
            .down_valid (link_valid[g+1]),
            .down_ready (link_ready[g+1]),
            .rem_out    (link_rem[g+1]),
            .den_out    (link_den[g+1]),
            .quot_out   (link_quot[g+1])
        );
    end

    // Last cell registers drive the output channel
    assign link_ready[QUOT_BITS] = out_ready;
    assign out_valid = link_valid[QUOT_BITS];
    assign red_out   = link_quot[QUOT_BITS][LANE_RED];
    assign green_out = link_quot[QUOT_BITS][LANE_GREEN];
    assign blue_out  = link_quot[QUOT_BITS][LANE_BLUE];

endmodule
